// ===== rtl/rlo_pkg.sv =====
package rlo_pkg;

    // Channel count defaults and the fixed width of the status words
    localparam int CHANNELS_DEF = 4;
    localparam int PIN_W        = 4;

    // Field widths
    localparam int CH_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int ELAPSED_W = 27;
    localparam int LIMIT_W   = 26;
    localparam int US_PER_MS = 1000;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

    // Item kinds
    typedef enum logic {
        OP_TICK = 1'b0,
        OP_SET  = 1'b1
    } t_op;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 3'd0,
        CFG_POLARITY   = 3'd1,
        CFG_INTERVAL_0 = 3'd2,
        CFG_INTERVAL_1 = 3'd3,
        CFG_INTERVAL_2 = 3'd4,
        CFG_INTERVAL_3 = 3'd5
    } t_cfg_reg;

    // Enable and polarity masks handed from the register file to the core
    typedef struct packed {
        logic [PIN_W-1:0] enable;
        logic [PIN_W-1:0] high_on;
    } t_pol;

endpackage

// ===== rtl/rlo_cfg.sv =====
module rlo_cfg
    import rlo_pkg::*;
#(
    parameter int NCH = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_pol                 o_pol,
    output logic [LIMIT_W-1:0]   o_limit [NCH]
);

    logic [PIN_W-1:0]   r_enable;
    logic [PIN_W-1:0]   r_high_on;
    logic [LIMIT_W-1:0] r_limit [NCH];
    logic [LIMIT_W-1:0] n_limit;

    // Scale the written interval to microseconds once, at write time
    assign n_limit = LIMIT_W'({{(LIMIT_W-CFG_DAT_W){1'b0}}, i_cfg_data}
                              * LIMIT_W'(US_PER_MS));

    // Write the masks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= '0;
            r_high_on <= '1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ENABLE) begin
                r_enable <= i_cfg_data[PIN_W-1:0];
            end
            if (i_cfg_index == CFG_POLARITY) begin
                r_high_on <= i_cfg_data[PIN_W-1:0];
            end
        end
    end

    // Write the per-channel limits
    for (genvar c = 0; c < NCH; c++) begin : g_limit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_limit[c] <= '0;
            end else if (i_cfg_valid &&
                         i_cfg_index == CFG_IDX_W'(CFG_INTERVAL_0 + c)) begin
                r_limit[c] <= n_limit;
            end
        end
        assign o_limit[c] = r_limit[c];
    end

    assign o_pol.enable  = r_enable;
    assign o_pol.high_on = r_high_on;

endmodule

// ===== rtl/rlo_core.sv =====
module rlo_core
    import rlo_pkg::*;
#(
    parameter int NCH = CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_op                i_op,
    input  logic [CH_W-1:0]    i_ch,
    input  logic               i_want,
    input  t_pol               i_pol,
    input  logic [LIMIT_W-1:0] i_limit [NCH],
    output logic               o_accepted,
    output logic [PIN_W-1:0]   o_pins,
    output logic [PIN_W-1:0]   o_states
);

    logic                 r_relay_on [NCH];
    logic                 n_relay_on [NCH];
    logic [ELAPSED_W-1:0] r_elapsed  [NCH];
    logic [ELAPSED_W-1:0] n_elapsed  [NCH];
    logic [NCH-1:0]       w_ok;

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        logic w_hit;
        logic w_same;
        logic w_due;

        // Decide the request for this channel; a zero limit always passes
        assign w_hit  = (i_op == OP_SET) && (i_ch == CH_W'(c)) && i_pol.enable[c];
        assign w_same = (r_relay_on[c] == i_want);
        assign w_due  = (r_elapsed[c] >= {1'b0, i_limit[c]});
        assign w_ok[c] = w_hit && (w_same || w_due);

        // Toggle on an honored change, otherwise count ticks
        always_comb begin
            n_relay_on[c] = r_relay_on[c];
            n_elapsed[c]  = r_elapsed[c];
            if (i_op == OP_TICK) begin
                if (r_elapsed[c] != ELAPSED_MAX) begin
                    n_elapsed[c] = r_elapsed[c] + 1'b1;
                end
            end else if (w_hit && !w_same && w_due) begin
                n_relay_on[c] = i_want;
                n_elapsed[c]  = '0;
            end
        end

        // Advance the channel state with the item
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_relay_on[c] <= 1'b0;
                r_elapsed[c]  <= '0;
            end else if (i_advance) begin
                r_relay_on[c] <= n_relay_on[c];
                r_elapsed[c]  <= n_elapsed[c];
            end
        end
    end

    assign o_accepted = (i_op == OP_TICK) || (|w_ok);

    // Map states to pin levels; unused bits read zero
    for (genvar p = 0; p < PIN_W; p++) begin : g_pin
        if (p < NCH) begin : g_live
            logic w_drive;
            assign w_drive     = i_pol.enable[p] && n_relay_on[p];
            assign o_pins[p]   = i_pol.high_on[p] ? w_drive : !w_drive;
            assign o_states[p] = n_relay_on[p];
        end else begin : g_none
            assign o_pins[p]   = 1'b0;
            assign o_states[p] = 1'b0;
        end
    end

endmodule

// ===== rtl/rate_limited_relay_outputs.sv =====
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_op, i_channel_index, i_want_on
// result    out        o_valid / i_stall      o_accepted, o_pin_levels, o_relay_states
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One word per cycle sustained while the result is not stalled; each word is captured
// in the input register and is then registered in the result register.
// Rate limits are scaled to microseconds when written, so the per-word path is
// one 27-bit compare and a saturating increment per channel.
// Reset (synchronous, active low) clears relay states, elapsed counters, enables
// and intervals, and sets every pin active high.
// A stalled result holds both registers; the input stalls only when both are full.
module rate_limited_relay_outputs
    import rlo_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic                 i_op,
    input  logic [CH_W-1:0]      i_channel_index,
    input  logic                 i_want_on,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_accepted,
    output logic [PIN_W-1:0]     o_pin_levels,
    output logic [PIN_W-1:0]     o_relay_states,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int NCH = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

    logic               r_in_valid;
    t_op                r_in_op;
    logic [CH_W-1:0]    r_in_ch;
    logic               r_in_want;
    logic               r_out_valid;
    logic               r_accepted;
    logic [PIN_W-1:0]   r_pins;
    logic [PIN_W-1:0]   r_states;
    logic               w_hold;
    logic               w_advance;
    logic               w_take;
    logic               w_accepted;
    logic [PIN_W-1:0]   w_pins;
    logic [PIN_W-1:0]   w_states;
    t_pol               w_pol;
    logic [LIMIT_W-1:0] w_limit [NCH];

    // Handshake
    assign w_hold    = r_out_valid && i_stall;
    assign w_advance = r_in_valid && !w_hold;
    assign o_stall   = r_in_valid && w_hold;
    assign w_take    = i_valid && !o_stall;

    assign o_cfg_ready = 1'b1;

    rlo_cfg #(
        .NCH (NCH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_pol       (w_pol),
        .o_limit     (w_limit)
    );

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_op   <= t_op'(i_op);
            r_in_ch   <= i_channel_index;
            r_in_want <= i_want_on;
        end
    end

    rlo_core #(
        .NCH (NCH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_op       (r_in_op),
        .i_ch       (r_in_ch),
        .i_want     (r_in_want),
        .i_pol      (w_pol),
        .i_limit    (w_limit),
        .o_accepted (w_accepted),
        .o_pins     (w_pins),
        .o_states   (w_states)
    );

    // Register the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_accepted <= w_accepted;
            r_pins     <= w_pins;
            r_states   <= w_states;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_accepted     = r_accepted;
    assign o_pin_levels   = r_pins;
    assign o_relay_states = r_states;

`ifndef SYNTHESIS
    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> o_valid)
        else $error("word advanced but no result registered");

    a_tick_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_op == OP_TICK) |=> o_accepted)
        else $error("tick word reported as refused");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled while a stage was free");
`endif

endmodule
